// ===== src/motion_energy_envelope_trigger_assert.svh =====
// assertion macros shared by the rtl files
`ifndef MOTION_ENERGY_ENVELOPE_TRIGGER_ASSERT_SVH
`define MOTION_ENERGY_ENVELOPE_TRIGGER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define MEE_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("implication check failed");

// next-cycle implication
`define MEE_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("next-cycle check failed");

`else

`define MEE_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define MEE_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

// ===== src/mee_pkg.sv =====
package mee_pkg;

    // grid geometry, rest position of a vertex is index * GRID_STEP pixels in q12.4
    localparam int GRID_STEP  = 8;
    localparam int REST_SCALE = GRID_STEP * 16;
    localparam int REST_W     = $clog2(64 * REST_SCALE);

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // shared unit widths
    localparam int OPND_W = 34;
    localparam int REM_W  = 20;
    localparam int QUO_W  = 32;
    localparam int CNT_W  = 6;
    localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(32);
    localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(17);

    // configuration register indexes
    localparam logic [2:0] CFG_X_START   = 3'd0;
    localparam logic [2:0] CFG_X_STOP    = 3'd1;
    localparam logic [2:0] CFG_Y_START   = 3'd2;
    localparam logic [2:0] CFG_Y_STOP    = 3'd3;
    localparam logic [2:0] CFG_MAX_SPEED = 3'd4;
    localparam logic [2:0] CFG_ATTACK    = 3'd5;
    localparam logic [2:0] CFG_RELEASE   = 3'd6;
    localparam logic [2:0] CFG_THRESHOLD = 3'd7;

    typedef enum logic {
        MODE_DIV,
        MODE_SQRT
    } iter_mode_t;

    typedef struct packed {
        logic       start;
        iter_mode_t mode;
    } iter_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } iter_rsp_t;

    typedef enum logic [1:0] {
        ST_OFF   = 2'd0,
        ST_TPLAY = 2'd1,
        ST_ON    = 2'd2,
        ST_TSTOP = 2'd3
    } play_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_X,
        S_MUL_Y,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_ACCUM,
        S_FINAL,
        S_DIV_SUM_GO,
        S_DIV_SUM_WAIT,
        S_DIV_LVL_GO,
        S_DIV_LVL_WAIT,
        S_ENV_COEF,
        S_ENV_MUL_OLD,
        S_ENV_MUL_NEW,
        S_EMIT
    } seq_state_t;

endpackage

// ===== src/mee_iter_unit.sv =====
`include "motion_energy_envelope_trigger_assert.svh"

// shared restoring unit: long division one bit per step, integer square root
// one result bit (two radicand bits) per step
module mee_iter_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mee_pkg::iter_req_t         req,
    input  logic [mee_pkg::OPND_W-1:0] opnd,
    input  logic [15:0]                divisor,
    output mee_pkg::iter_rsp_t         rsp,
    output logic [mee_pkg::QUO_W-1:0]  result
);
    import mee_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    iter_mode_t       mode_reg;
    logic [OPND_W-1:0] opnd_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [15:0]       divisor_reg;

    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;
    logic [REM_W:0]   diff;
    logic             fits;

    // one step of the shared compare and subtract
    always_comb
    begin
        if (mode_reg == MODE_DIV)
        begin
            shifted = {rem_reg[REM_W-2:0], opnd_reg[OPND_W-1]};
            trial   = {{(REM_W-16){1'b0}}, divisor_reg};
        end
        else
        begin
            shifted = {rem_reg[REM_W-3:0], opnd_reg[OPND_W-1:OPND_W-2]};
            trial   = {1'b0, quo_reg[16:0], 2'b01};
        end
        diff = {1'b0, shifted} - {1'b0, trial};
        fits = !diff[REM_W];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = (req.mode == MODE_DIV) ? DIV_STEPS : SQRT_STEPS;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mode_reg    <= req.mode;
            opnd_reg    <= opnd;
            divisor_reg <= divisor;
            rem_reg     <= '0;
            quo_reg     <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[REM_W-1:0] : shifted;
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
            if (mode_reg == MODE_DIV)
            begin
                opnd_reg <= {opnd_reg[OPND_W-2:0], 1'b0};
            end
            else
            begin
                opnd_reg <= {opnd_reg[OPND_W-3:0], 2'b00};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign result   = quo_reg;

    `MEE_ASSERT_IMPLIES(a_no_restart, clk, rst_n, req.start, !busy_reg)
    `MEE_ASSERT_IMPLIES(a_done_after_busy, clk, rst_n, done_reg, !busy_reg && $past(busy_reg))
    `MEE_ASSERT_NEXT(a_start_busy, clk, rst_n, req.start, busy_reg)

endmodule

// ===== src/motion_energy_envelope_trigger.sv =====
// motion energy envelope trigger
//
// input stream s_*: one mesh vertex per word, s_tlast marks the last vertex of
// a frame. vertices inside the configured grid region add their distance from
// rest to a running sum; the word with s_tlast closes the frame and yields one
// result word on m_* holding the new envelope volume and the trigger state.
// config channel cfg_*: register index and data, always ready; write only
// while the block is idle.
//
// a vertex outside the region needs no further work. a vertex inside is
// squared along x and y on the multiplier, then waits for the 17 steps of the
// square root in the shared iterative unit. closing a frame runs two 32-step
// divisions (mean, then normalized level) in the same unit, then the envelope
// coefficient pick and two products on the single 17x17 multiplier; an empty
// region skips the divisions. s_tready is high only while the sequencer is idle.
// reset clears the sum, count, envelope volume and trigger state and loads
// the default region, clamp, coefficients and threshold.
// the result sits in an output register; new vertices are taken while it
// waits, and only the next frame end holds off until m_tready takes it.
`include "motion_energy_envelope_trigger_assert.svh"

module motion_energy_envelope_trigger (
    input  logic        clk,
    input  logic        rst_n,
    // vertex stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // grid_col[5:0], grid_row[11:6], vertex_x[27:12],
                                   // vertex_y[43:28], zero fill[47:44]
    input  logic        s_tlast,   // frame_end
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // volume_level[16:0], trigger_state[18:17],
                                   // zero fill[23:19]
    // config writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    import mee_pkg::*;

    // config registers
    logic [5:0]  x_start_reg, y_start_reg;
    logic [6:0]  x_stop_reg, y_stop_reg;
    logic [15:0] max_speed_reg;
    logic [16:0] attack_reg, release_reg, threshold_reg;

    // sequencer and frame state
    seq_state_t  state_reg, state_next;
    play_state_t play_reg, play_next;
    logic [31:0] sum_reg;
    logic [12:0] count_reg;
    logic [16:0] vol_reg;
    logic        out_valid_reg;
    logic [18:0] out_data_reg;

    // per-item datapath
    logic        last_reg;
    logic [15:0] dx_abs_reg, dy_abs_reg;
    logic [33:0] prod_reg;
    logic [31:0] sq_reg;
    logic [15:0] mean_reg;
    logic [16:0] level_reg;
    logic [16:0] z_reg;
    logic [33:0] acc_reg;

    // input word fields
    logic [5:0]  grid_col, grid_row;
    logic [15:0] vertex_x, vertex_y;
    logic        frame_end;
    assign grid_col  = s_tdata[5:0];
    assign grid_row  = s_tdata[11:6];
    assign vertex_x  = s_tdata[27:12];
    assign vertex_y  = s_tdata[43:28];
    assign frame_end = s_tlast;

    logic        in_accept;
    logic        in_region;
    logic [REST_W-1:0] rest_x, rest_y;
    logic [16:0] dx, dy;
    logic [15:0] dx_abs, dy_abs;
    logic [15:0] ms;

    // shared unit and multiplier
    iter_req_t         iter_req;
    iter_rsp_t         iter_rsp;
    logic [OPND_W-1:0] iter_opnd;
    logic [15:0]       iter_divisor;
    logic [QUO_W-1:0]  iter_result;
    logic [16:0]       mul_a, mul_b;
    logic [33:0]       mul_p;

    logic        out_free;
    logic        emit;
    logic [32:0] sum_wide;
    logic [34:0] acc_round;
    logic [16:0] vol_new;
    logic [16:0] z_pick;

    assign in_accept = s_tvalid && s_tready;
    assign ms        = (max_speed_reg == 16'd0) ? 16'd1 : max_speed_reg;

    assign in_region = (grid_col >= x_start_reg) && ({1'b0, grid_col} < x_stop_reg)
                    && (grid_row >= y_start_reg) && ({1'b0, grid_row} < y_stop_reg);

    // displacement from rest, q12.4
    assign rest_x = REST_W'(grid_col) * REST_W'(REST_SCALE);
    assign rest_y = REST_W'(grid_row) * REST_W'(REST_SCALE);
    assign dx     = {1'b0, vertex_x} - 17'(rest_x);
    assign dy     = {1'b0, vertex_y} - 17'(rest_y);
    assign dx_abs = dx[16] ? 16'(-dx) : dx[15:0];
    assign dy_abs = dy[16] ? 16'(-dy) : dy[15:0];

    assign mul_p = mul_a * mul_b;

    assign out_free = !out_valid_reg || m_tready;

    // envelope: weighted old volume plus weighted level, round half up, capped at one
    assign acc_round = {1'b0, acc_reg} + 35'd32768;
    assign vol_new   = (acc_round[34:16] > 19'(ONE_Q16)) ? ONE_Q16 : acc_round[32:16];
    assign z_pick    = (level_reg > vol_reg) ? attack_reg : release_reg;

    assign sum_wide = {1'b0, sum_reg} + {16'd0, iter_result[16:0]};

    // trigger machine against the updated volume
    always_comb
    begin
        play_next = play_reg;
        if (vol_new < threshold_reg)
        begin
            case (play_reg)
                ST_TSTOP: play_next = ST_OFF;
                ST_ON:    play_next = ST_TSTOP;
                ST_TPLAY: play_next = ST_TSTOP;
                default:  play_next = play_reg;
            endcase
        end
        else
        begin
            case (play_reg)
                ST_TPLAY: play_next = ST_ON;
                ST_OFF:   play_next = ST_TPLAY;
                ST_TSTOP: play_next = ST_TPLAY;
                default:  play_next = play_reg;
            endcase
        end
    end

    // sequencer next state and control
    always_comb
    begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        iter_req      = '{start: 1'b0, mode: MODE_DIV};
        iter_opnd     = '0;
        iter_divisor  = '0;
        mul_a         = '0;
        mul_b         = '0;
        emit          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (in_region)
                    begin
                        state_next = S_MUL_X;
                    end
                    else if (frame_end)
                    begin
                        state_next = S_FINAL;
                    end
                end
            end
            S_MUL_X:
            begin
                mul_a      = {1'b0, dx_abs_reg};
                mul_b      = {1'b0, dx_abs_reg};
                state_next = S_MUL_Y;
            end
            S_MUL_Y:
            begin
                mul_a      = {1'b0, dy_abs_reg};
                mul_b      = {1'b0, dy_abs_reg};
                state_next = S_SQRT_GO;
            end
            S_SQRT_GO:
            begin
                iter_req   = '{start: 1'b1, mode: MODE_SQRT};
                iter_opnd  = {1'b0, {1'b0, sq_reg} + {1'b0, prod_reg[31:0]}};
                state_next = S_SQRT_WAIT;
            end
            S_SQRT_WAIT:
            begin
                if (iter_rsp.done)
                begin
                    state_next = S_ACCUM;
                end
            end
            S_ACCUM:
            begin
                state_next = last_reg ? S_FINAL : S_IDLE;
            end
            S_FINAL:
            begin
                state_next = (count_reg == 13'd0) ? S_ENV_COEF : S_DIV_SUM_GO;
            end
            S_DIV_SUM_GO:
            begin
                iter_req     = '{start: 1'b1, mode: MODE_DIV};
                iter_opnd    = {sum_reg, 2'b00};
                iter_divisor = {3'b000, count_reg};
                state_next   = S_DIV_SUM_WAIT;
            end
            S_DIV_SUM_WAIT:
            begin
                if (iter_rsp.done)
                begin
                    state_next = S_DIV_LVL_GO;
                end
            end
            S_DIV_LVL_GO:
            begin
                iter_req     = '{start: 1'b1, mode: MODE_DIV};
                iter_opnd    = {mean_reg, 16'd0, 2'b00};
                iter_divisor = ms;
                state_next   = S_DIV_LVL_WAIT;
            end
            S_DIV_LVL_WAIT:
            begin
                if (iter_rsp.done)
                begin
                    state_next = S_ENV_COEF;
                end
            end
            S_ENV_COEF:
            begin
                state_next = S_ENV_MUL_OLD;
            end
            S_ENV_MUL_OLD:
            begin
                mul_a      = vol_reg;
                mul_b      = ONE_Q16 - z_reg;
                state_next = S_ENV_MUL_NEW;
            end
            S_ENV_MUL_NEW:
            begin
                mul_a      = level_reg;
                mul_b      = z_reg;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold here until the output register is free
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    mee_iter_unit u_iter (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (iter_req),
        .opnd    (iter_opnd),
        .divisor (iter_divisor),
        .rsp     (iter_rsp),
        .result  (iter_result)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            play_reg      <= ST_OFF;
            sum_reg       <= '0;
            count_reg     <= '0;
            vol_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_ACCUM)
            begin
                // saturating sum and count
                sum_reg <= sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
                if (count_reg != 13'h1FFF)
                begin
                    count_reg <= count_reg + 13'd1;
                end
            end
            if (emit)
            begin
                vol_reg   <= vol_new;
                play_reg  <= play_next;
                sum_reg   <= '0;
                count_reg <= '0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_start_reg   <= 6'd0;
            x_stop_reg    <= 7'd64;
            y_start_reg   <= 6'd0;
            y_stop_reg    <= 7'd64;
            max_speed_reg <= 16'd160;
            attack_reg    <= 17'd32768;
            release_reg   <= 17'd64881;
            threshold_reg <= 17'd6554;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_X_START:   x_start_reg   <= cfg_data[5:0];
                CFG_X_STOP:    x_stop_reg    <= cfg_data[6:0];
                CFG_Y_START:   y_start_reg   <= cfg_data[5:0];
                CFG_Y_STOP:    y_stop_reg    <= cfg_data[6:0];
                CFG_MAX_SPEED: max_speed_reg <= cfg_data[15:0];
                CFG_ATTACK:    attack_reg    <= cfg_data;
                CFG_RELEASE:   release_reg   <= cfg_data;
                CFG_THRESHOLD: threshold_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            last_reg   <= frame_end;
            dx_abs_reg <= dx_abs;
            dy_abs_reg <= dy_abs;
        end
        case (state_reg)
            S_MUL_X:
            begin
                prod_reg <= mul_p;
            end
            S_MUL_Y:
            begin
                sq_reg   <= prod_reg[31:0];
                prod_reg <= mul_p;
            end
            S_FINAL:
            begin
                level_reg <= '0;
            end
            S_DIV_SUM_WAIT:
            begin
                if (iter_rsp.done)
                begin
                    // clamp the mean to the speed limit
                    mean_reg <= (iter_result > {16'd0, ms}) ? ms : iter_result[15:0];
                end
            end
            S_DIV_LVL_WAIT:
            begin
                if (iter_rsp.done)
                begin
                    level_reg <= iter_result[16:0];
                end
            end
            S_ENV_COEF:
            begin
                z_reg <= (z_pick > ONE_Q16) ? ONE_Q16 : z_pick;
            end
            S_ENV_MUL_OLD:
            begin
                prod_reg <= mul_p;
            end
            S_ENV_MUL_NEW:
            begin
                acc_reg <= prod_reg + mul_p;
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
        if (emit)
        begin
            out_data_reg <= {play_next, vol_new};
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'd0, out_data_reg};
    assign cfg_ready = 1'b1;

    `MEE_ASSERT_IMPLIES(a_vol_in_range, clk, rst_n, 1'b1, vol_reg <= ONE_Q16)
    `MEE_ASSERT_IMPLIES(a_done_when_waiting, clk, rst_n, iter_rsp.done,
        state_reg == S_SQRT_WAIT || state_reg == S_DIV_SUM_WAIT || state_reg == S_DIV_LVL_WAIT)
    `MEE_ASSERT_IMPLIES(a_ready_when_free, clk, rst_n, s_tready, !iter_rsp.busy)
    `MEE_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule
